>>> design/loop_chunk_range_partitioner_defines.svh
// ----------------------------------------------------------------------------
// Loop chunk range partitioner assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef LOOP_CHUNK_RANGE_PARTITIONER_DEFINES_SVH
`define LOOP_CHUNK_RANGE_PARTITIONER_DEFINES_SVH

`define LCRP_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("lcrp: invariant failed");

`define LCRP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lcrp: implication failed");

`define LCRP_ASSERT_DELAY(lbl, clk, rst_n, ante, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
		else $error("lcrp: delayed implication failed");

`endif

>>> design/lcrp_pkg.sv
// ----------------------------------------------------------------------------
// Loop chunk range partitioner package
// Widths, mode and register codes, pipeline context and latency figures.
// ----------------------------------------------------------------------------
`default_nettype none

package lcrp_pkg;

	localparam int DIV_NW = 33;
	localparam int DIV_DW = 17;
	localparam int SPLIT_STAGES = 5;
	localparam int FIN_STAGES = 3;
	localparam int LCRP_LATENCY = 3 * DIV_NW + SPLIT_STAGES + FIN_STAGES;

	localparam logic [1:0] MODE_FLAT      = 2'd0;
	localparam logic [1:0] MODE_BLOCK_CYC = 2'd1;
	localparam logic [1:0] MODE_TWO_LEVEL = 2'd2;
	localparam logic [1:0] MODE_TILE      = 2'd3;

	localparam logic [1:0] CFG_MODE    = 2'd0;
	localparam logic [1:0] CFG_TOTAL   = 2'd1;
	localparam logic [1:0] CFG_PERNODE = 2'd2;
	localparam logic [1:0] CFG_COLUMNS = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] id;
		logic [31:0] iters;
		logic [31:0] chunks;
		logic [31:0] bsize;
		logic [16:0] wpn;
		logic [15:0] pid;
		logic [15:0] thr;
		logic        pzero;
		logic [63:0] n_start;
		logic [63:0] hint;
		logic [31:0] cnt;
	} lcrp_ctx_t;

	function automatic logic [16:0] nz17(input logic [16:0] v);
		return (v == 17'd0) ? 17'd1 : v;
	endfunction

endpackage

`default_nettype wire

>>> design/loop_chunk_range_partitioner.sv
// ----------------------------------------------------------------------------
// Loop chunk range partitioner
// Per-worker iteration range and acquire window for four distribution modes.
// ----------------------------------------------------------------------------
// Pipeline: three 33-stage dividers in series (a fourth runs beside the
// first), 5-stage split/scale, 3-stage thread split and output register.
// Throughput: one word per cycle; busy stays low.
// Reset: clears the valid chain and sets mode flat, all worker counts to one.
`default_nettype none

module loop_chunk_range_partitioner import lcrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] worker_id,
	input  logic [31:0] total_iterations,
	input  logic [31:0] total_chunks,
	input  logic [31:0] chunk_size,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [16:0] cfg_wdata,
	output logic        done,
	output logic [63:0] iter_start,
	output logic [31:0] iter_count,
	output logic [63:0] iter_count_hint,
	output logic        has_work,
	output logic [63:0] acquire_start,
	output logic [31:0] acquire_size,
	output logic [63:0] acquire_size_hint
);

	logic [1:0]  mode_q;
	logic [16:0] total_q;
	logic [16:0] pernode_q;
	logic [16:0] columns_q;

	logic              accept;
	logic [16:0]       d1;
	lcrp_ctx_t         ctx_a;
	logic              va;
	logic [DIV_NW-1:0] qa, qb, qc, qd;
	logic [DIV_DW-1:0] rb, rc;
	lcrp_ctx_t         ctx_pa, ctx_c, ctx_pc, ctx_s, ctx_pd;
	logic              vc, vs, vd;
	logic [DIV_NW-1:0] num_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_FLAT;
			total_q   <= 17'd1;
			pernode_q <= 17'd1;
			columns_q <= 17'd1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_MODE:    mode_q    <= cfg_wdata[1:0];
				CFG_TOTAL:   total_q   <= cfg_wdata;
				CFG_PERNODE: pernode_q <= cfg_wdata;
				CFG_COLUMNS: columns_q <= cfg_wdata;
			endcase
		end
	end

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	always_comb begin
		unique case (mode_q)
			MODE_TWO_LEVEL: d1 = nz17(pernode_q);
			MODE_TILE:      d1 = nz17(columns_q);
			default:        d1 = 17'd1;
		endcase
		ctx_a        = '0;
		ctx_a.mode   = mode_q;
		ctx_a.id     = worker_id;
		ctx_a.iters  = total_iterations;
		ctx_a.chunks = total_chunks;
		ctx_a.bsize  = chunk_size;
		ctx_a.wpn    = nz17(pernode_q);
	end

	lcrp_div u_div_parts (
		.clk(clk), .arst_n(arst_n), .valid_i(accept),
		.num_i({16'd0, total_q}), .den_i(d1), .ctx_i(ctx_a),
		.valid_o(va), .quo_o(qa), .rem_o(), .ctx_o(ctx_pa)
	);

	lcrp_div u_div_id (
		.clk(clk), .arst_n(arst_n), .valid_i(accept),
		.num_i({17'd0, worker_id}), .den_i(d1), .ctx_i(ctx_a),
		.valid_o(), .quo_o(qb), .rem_o(rb), .ctx_o()
	);

	always_comb begin
		ctx_c       = ctx_pa;
		ctx_c.pid   = qb[15:0];
		ctx_c.thr   = rb[15:0];
		ctx_c.pzero = qa[16:0] == 17'd0;
	end

	lcrp_div u_div_chunks (
		.clk(clk), .arst_n(arst_n), .valid_i(va),
		.num_i({1'b0, ctx_pa.chunks}), .den_i(qa[16:0]), .ctx_i(ctx_c),
		.valid_o(vc), .quo_o(qc), .rem_o(rc), .ctx_o(ctx_pc)
	);

	lcrp_split u_split (
		.clk(clk), .arst_n(arst_n), .valid_i(vc),
		.quo_i(qc[31:0]), .rem_i(rc), .ctx_i(ctx_pc),
		.valid_o(vs), .ctx_o(ctx_s)
	);

	assign num_d = {1'b0, ctx_s.cnt} + {16'd0, ctx_s.wpn} - 33'd1;

	lcrp_div u_div_rows (
		.clk(clk), .arst_n(arst_n), .valid_i(vs),
		.num_i(num_d), .den_i(ctx_s.wpn), .ctx_i(ctx_s),
		.valid_o(vd), .quo_o(qd), .rem_o(), .ctx_o(ctx_pd)
	);

	lcrp_fin u_fin (
		.clk(clk), .arst_n(arst_n), .valid_i(vd),
		.sub_i(qd), .ctx_i(ctx_pd),
		.done(done), .iter_start(iter_start), .iter_count(iter_count),
		.iter_count_hint(iter_count_hint), .has_work(has_work),
		.acquire_start(acquire_start), .acquire_size(acquire_size),
		.acquire_size_hint(acquire_size_hint)
	);

endmodule

`default_nettype wire

>>> design/lcrp_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; context word travels alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module lcrp_div import lcrp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_i,
	input  logic [DIV_NW-1:0]   num_i,
	input  logic [DIV_DW-1:0]   den_i,
	input  lcrp_ctx_t           ctx_i,
	output logic                valid_o,
	output logic [DIV_NW-1:0]   quo_o,
	output logic [DIV_DW-1:0]   rem_o,
	output lcrp_ctx_t           ctx_o
);

	logic              vld_p [0:DIV_NW];
	logic [DIV_NW-1:0] num_p [0:DIV_NW];
	logic [DIV_DW-1:0] den_p [0:DIV_NW];
	logic [DIV_DW-1:0] rem_p [0:DIV_NW];
	logic [DIV_NW-1:0] quo_p [0:DIV_NW];
	lcrp_ctx_t         ctx_p [0:DIV_NW];

	assign vld_p[0] = valid_i;
	assign num_p[0] = num_i;
	assign den_p[0] = den_i;
	assign rem_p[0] = '0;
	assign quo_p[0] = '0;
	assign ctx_p[0] = ctx_i;

	for (genvar k = 0; k < DIV_NW; k++) begin : g_stage
		logic [DIV_DW:0]   trial;
		logic              ge;
		logic [DIV_DW:0]   diff;

		assign trial = {rem_p[k], num_p[k][DIV_NW-1-k]};
		assign ge    = trial >= {1'b0, den_p[k]};
		assign diff  = trial - {1'b0, den_p[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_p[k+1] <= 1'b0;
			end else begin
				vld_p[k+1] <= vld_p[k];
			end
		end

		always_ff @(posedge clk) begin
			num_p[k+1] <= num_p[k];
			den_p[k+1] <= den_p[k];
			ctx_p[k+1] <= ctx_p[k];
			rem_p[k+1] <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
			quo_p[k+1] <= {quo_p[k][DIV_NW-2:0], ge};
		end
	end

	assign valid_o = vld_p[DIV_NW];
	assign quo_o   = quo_p[DIV_NW];
	assign rem_o   = rem_p[DIV_NW];
	assign ctx_o   = ctx_p[DIV_NW];

endmodule

`default_nettype wire

>>> design/lcrp_split.sv
// ----------------------------------------------------------------------------
// Chunk split and scale
// Floor-plus-remainder split, scaling by block size and loop-end clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module lcrp_split import lcrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_i,
	input  logic [31:0] quo_i,
	input  logic [16:0] rem_i,
	input  lcrp_ctx_t   ctx_i,
	output logic        valid_o,
	output lcrp_ctx_t   ctx_o
);

	logic [31:0] base;
	logic [16:0] remv;
	logic [16:0] pid_x;
	logic [16:0] mn;
	logic [31:0] cval;

	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	lcrp_ctx_t   ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5;
	logic [31:0] c_s1;
	logic [47:0] pb_s1;
	logic [16:0] mn_s1;
	logic [48:0] s_s2;
	logic [63:0] plo_s3;
	logic [48:0] phi_full;
	logic [31:0] phi_s3;
	logic [63:0] left;
	logic [63:0] cnt64;
	lcrp_ctx_t   ctx_hint;
	lcrp_ctx_t   ctx_start;
	lcrp_ctx_t   ctx_cnt;

	assign base  = ctx_i.pzero ? 32'd0 : quo_i;
	assign remv  = ctx_i.pzero ? 17'd0 : rem_i;
	assign pid_x = {1'b0, ctx_i.pid};
	assign mn    = (pid_x < remv) ? pid_x : remv;
	assign cval  = (pid_x < remv) ? base + 32'd1 : base;

	assign phi_full = {32'd0, s_s2[48:32]} * {17'd0, ctx_s2.bsize};

	assign left  = (ctx_s4.n_start >= {32'd0, ctx_s4.iters}) ? 64'd0
		: {32'd0, ctx_s4.iters} - ctx_s4.n_start;
	assign cnt64 = (ctx_s4.hint < left) ? ctx_s4.hint : left;

	always_comb begin
		ctx_hint         = ctx_s1;
		ctx_hint.hint    = {32'd0, c_s1} * {32'd0, ctx_s1.bsize};
		ctx_start        = ctx_s3;
		ctx_start.n_start = plo_s3 + {phi_s3, 32'd0};
		ctx_cnt          = ctx_s4;
		ctx_cnt.cnt      = cnt64[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= valid_i;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s1 <= ctx_i;
		c_s1   <= cval;
		pb_s1  <= {16'd0, ctx_i.pid} * {16'd0, base};
		mn_s1  <= mn;

		ctx_s2 <= ctx_hint;
		s_s2   <= {1'b0, pb_s1} + {32'd0, mn_s1};

		ctx_s3 <= ctx_s2;
		plo_s3 <= {32'd0, s_s2[31:0]} * {32'd0, ctx_s2.bsize};
		phi_s3 <= phi_full[31:0];

		ctx_s4 <= ctx_start;

		ctx_s5 <= ctx_cnt;
	end

	assign valid_o = v_s5;
	assign ctx_o   = ctx_s5;

endmodule

`default_nettype wire

>>> design/lcrp_fin.sv
// ----------------------------------------------------------------------------
// Thread sub-split and result select
// Splits node rows over threads and selects the result word per mode.
// ----------------------------------------------------------------------------
`default_nettype none

module lcrp_fin import lcrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_i,
	input  logic [32:0] sub_i,
	input  lcrp_ctx_t   ctx_i,
	output logic        done,
	output logic [63:0] iter_start,
	output logic [31:0] iter_count,
	output logic [63:0] iter_count_hint,
	output logic        has_work,
	output logic [63:0] acquire_start,
	output logic [31:0] acquire_size,
	output logic [63:0] acquire_size_hint
);

	logic        v_s1, v_s2, done_q;
	lcrp_ctx_t   ctx_s1, ctx_s2;
	logic [32:0] sub_s1, sub_s2;
	logic [48:0] lst_s1;
	logic [48:0] rows;
	logic [48:0] left2;
	logic [48:0] cnt2;
	logic [31:0] cnt2_s2;
	logic [63:0] s2_s2;

	assign rows  = {17'd0, ctx_s1.cnt};
	assign left2 = (lst_s1 >= rows) ? 49'd0 : rows - lst_s1;
	assign cnt2  = ({16'd0, sub_s1} < left2) ? {16'd0, sub_s1} : left2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= valid_i;
			v_s2   <= v_s1;
			done_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s1 <= ctx_i;
		sub_s1 <= sub_i;
		lst_s1 <= {17'd0, ctx_i.thr} * {16'd0, sub_i};

		ctx_s2  <= ctx_s1;
		sub_s2  <= sub_s1;
		cnt2_s2 <= cnt2[31:0];
		s2_s2   <= ctx_s1.n_start + {15'd0, lst_s1};

		unique case (ctx_s2.mode)
			MODE_BLOCK_CYC: begin
				iter_start        <= '0;
				iter_count        <= '0;
				iter_count_hint   <= '0;
				has_work          <= {16'd0, ctx_s2.id} < ctx_s2.chunks;
				acquire_start     <= '0;
				acquire_size      <= ctx_s2.iters;
				acquire_size_hint <= {32'd0, ctx_s2.iters};
			end
			MODE_TWO_LEVEL: begin
				iter_start        <= s2_s2;
				iter_count        <= cnt2_s2;
				iter_count_hint   <= {31'd0, sub_s2};
				has_work          <= cnt2_s2 != 32'd0;
				acquire_start     <= ctx_s2.n_start;
				acquire_size      <= ctx_s2.cnt;
				acquire_size_hint <= ctx_s2.hint;
			end
			default: begin
				iter_start        <= ctx_s2.n_start;
				iter_count        <= ctx_s2.cnt;
				iter_count_hint   <= ctx_s2.hint;
				has_work          <= ctx_s2.cnt != 32'd0;
				acquire_start     <= ctx_s2.n_start;
				acquire_size      <= ctx_s2.cnt;
				acquire_size_hint <= ctx_s2.hint;
			end
		endcase
	end

	assign done = done_q;

endmodule

`default_nettype wire

>>> design/lcrp_chk.sv
// ----------------------------------------------------------------------------
// Loop chunk range partitioner port checker
// Watches the top-level ports for latency and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none
`include "loop_chunk_range_partitioner_defines.svh"

module lcrp_chk import lcrp_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [31:0] iter_count,
	input wire logic [63:0] iter_count_hint,
	input wire logic        has_work,
	input wire logic [31:0] acquire_size,
	input wire logic [63:0] acquire_size_hint
);

	`LCRP_ASSERT_ALWAYS(a_never_busy, clk, arst_n, !busy)
	`LCRP_ASSERT_DELAY(a_latency, clk, arst_n, start && !busy, LCRP_LATENCY, done)
	`LCRP_ASSERT_IMPL(a_cnt_le_hint, clk, arst_n, done, ({32'd0, iter_count} <= iter_count_hint))
	`LCRP_ASSERT_IMPL(a_cnt_has, clk, arst_n, done && iter_count != 32'd0, has_work)
	`LCRP_ASSERT_IMPL(a_acq_le_hint, clk, arst_n, done, ({32'd0, acquire_size} <= acquire_size_hint))

endmodule

bind loop_chunk_range_partitioner lcrp_chk u_lcrp_chk (.*);

`default_nettype wire

>>> tb/sv/loop_chunk_range_partitioner_tb.sv
// ----------------------------------------------------------------------------
// Loop chunk range partitioner testbench
// Drives range queries in all four modes under several register settings,
// predicts each result word and compares it field by field as it appears.
// ----------------------------------------------------------------------------
`default_nettype none

module loop_chunk_range_partitioner_tb;
	import lcrp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [63:0] iter_start;
		logic [31:0] iter_count;
		logic [63:0] iter_count_hint;
		logic        has_work;
		logic [63:0] acquire_start;
		logic [31:0] acquire_size;
		logic [63:0] acquire_size_hint;
	} range_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [15:0] worker_id;
	logic [31:0] total_iterations;
	logic [31:0] total_chunks;
	logic [31:0] chunk_size;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [16:0] cfg_wdata;
	logic        done;
	logic [63:0] iter_start;
	logic [31:0] iter_count;
	logic [63:0] iter_count_hint;
	logic        has_work;
	logic [63:0] acquire_start;
	logic [31:0] acquire_size;
	logic [63:0] acquire_size_hint;

	logic [1:0]  mode_q;
	logic [16:0] workers_q;
	logic [16:0] per_node_q;
	logic [16:0] columns_q;

	range_t      ranges_due[$];
	int          errors = 0;
	int          idle_cnt = 0;
	int          gap_pct;

	loop_chunk_range_partitioner i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void split(input logic [63:0] items, input logic [63:0] parts,
			input logic [63:0] id, output logic [63:0] s, output logic [63:0] c);
		logic [63:0] base;
		logic [63:0] rem;
		if (parts == 64'd0) begin
			s = 64'd0;
			c = 64'd0;
			return;
		end
		base = items / parts;
		rem = items % parts;
		c = (id < rem) ? base + 64'd1 : base;
		s = id * base + ((id < rem) ? id : rem);
	endfunction

	function automatic logic [63:0] clamp(input logic [63:0] want, input logic [63:0] s,
			input logic [63:0] lim);
		logic [63:0] left;
		left = (s >= lim) ? 64'd0 : lim - s;
		return (want < left) ? want : left;
	endfunction

	function automatic range_t predict_range(input logic [15:0] wid, input logic [31:0] its,
			input logic [31:0] chs, input logic [31:0] bs);
		range_t r;
		logic [63:0] s, c, wpn, parts, pid, n_start, n_max, n_rows, sub, l_start, cnt;
		r = '0;
		if (mode_q == MODE_BLOCK_CYC) begin
			r.has_work = ({48'd0, wid} < {32'd0, chs});
			r.acquire_size = its;
			r.acquire_size_hint = {32'd0, its};
		end else if (mode_q == MODE_TWO_LEVEL) begin
			wpn = (per_node_q == 17'd0) ? 64'd1 : {47'd0, per_node_q};
			split({32'd0, chs}, {47'd0, workers_q} / wpn, {48'd0, wid} / wpn, s, c);
			n_start = s * {32'd0, bs};
			n_max = c * {32'd0, bs};
			n_rows = clamp(n_max, n_start, {32'd0, its});
			sub = (n_rows + (wpn - 64'd1)) / wpn;
			l_start = ({48'd0, wid} % wpn) * sub;
			cnt = clamp(sub, l_start, n_rows);
			r.iter_start = n_start + l_start;
			r.iter_count = cnt[31:0];
			r.iter_count_hint = sub;
			r.has_work = (cnt != 64'd0);
			r.acquire_start = n_start;
			r.acquire_size = n_rows[31:0];
			r.acquire_size_hint = n_max;
		end else begin
			parts = {47'd0, workers_q};
			pid = {48'd0, wid};
			if (mode_q == MODE_TILE) begin
				wpn = (columns_q == 17'd0) ? 64'd1 : {47'd0, columns_q};
				parts = parts / wpn;
				pid = pid / wpn;
			end
			split({32'd0, chs}, parts, pid, s, c);
			s = s * {32'd0, bs};
			c = c * {32'd0, bs};
			cnt = clamp(c, s, {32'd0, its});
			r.iter_start = s;
			r.iter_count = cnt[31:0];
			r.iter_count_hint = c;
			r.has_work = (cnt != 64'd0);
			r.acquire_start = s;
			r.acquire_size = cnt[31:0];
			r.acquire_size_hint = c;
		end
		return r;
	endfunction

	task automatic send_query(input logic [15:0] wid, input logic [31:0] its,
			input logic [31:0] chs, input logic [31:0] bs);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		worker_id <= wid;
		total_iterations <= its;
		total_chunks <= chs;
		chunk_size <= bs;
		@(posedge clk);
		while (busy) @(posedge clk);
		ranges_due.push_back(predict_range(wid, its, chs, bs));
		@(negedge clk);
	endtask

	task automatic drain;
		start <= 1'b0;
		while (ranges_due.size() != 0) @(negedge clk);
		repeat (LCRP_LATENCY + 10) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		case (idx)
			CFG_MODE:    mode_q = val[1:0];
			CFG_TOTAL:   workers_q = val;
			CFG_PERNODE: per_node_q = val;
			default:     columns_q = val;
		endcase
	endtask

	task automatic set_all(input logic [1:0] m, input logic [16:0] tw,
			input logic [16:0] wpn, input logic [16:0] cols);
		drain();
		write_reg(CFG_MODE, {15'd0, m});
		write_reg(CFG_TOTAL, tw);
		write_reg(CFG_PERNODE, wpn);
		write_reg(CFG_COLUMNS, cols);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] rand32;
		case ($urandom_range(3))
			0: return $urandom_range(16);
			1: return $urandom_range(5000);
			2: return 32'hFFFF_FFFF - $urandom_range(3);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [16:0] rand_workers;
		case ($urandom_range(5))
			0: return 17'd0;
			1: return 17'h10000;
			2: return 17'h1FFFF;
			3: return 17'($urandom);
			default: return 17'($urandom_range(1, 64));
		endcase
	endfunction

	task automatic test_directed;
		logic [1:0] m;
		for (int k = 0; k < 4; k++) begin
			m = 2'(k);
			set_all(m, 17'd8, 17'd2, 17'd4);
			send_query(16'd0, 32'd100, 32'd10, 32'd10);
			send_query(16'd7, 32'd95, 32'd10, 32'd10);
			send_query(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
			send_query(16'd3, 32'd0, 32'd0, 32'd1);
			send_query(16'd1, 32'd50, 32'd9, 32'd0);
		end
		set_all(MODE_TWO_LEVEL, 17'd1, 17'd4, 17'd0);
		send_query(16'd0, 32'd100, 32'd10, 32'd10);
		set_all(MODE_TILE, 17'd3, 17'd0, 17'd5);
		send_query(16'd0, 32'd100, 32'd10, 32'd10);
		set_all(MODE_TILE, 17'd7, 17'd1, 17'd0);
		send_query(16'd6, 32'd100, 32'd10, 32'd10);
		set_all(MODE_FLAT, 17'd0, 17'd1, 17'd1);
		send_query(16'd0, 32'd100, 32'd10, 32'd10);
		set_all(MODE_FLAT, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
		send_query(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
	endtask

	task automatic test_random(input int n_phase);
		logic [16:0] tw;
		logic [15:0] wid;
		for (int p = 0; p < n_phase; p++) begin
			tw = rand_workers();
			set_all(2'($urandom_range(3)), tw, rand_workers(), rand_workers());
			repeat (50) begin
				wid = ($urandom_range(3) == 0) ? 16'($urandom) :
					16'($urandom_range(tw + 2));
				send_query(wid, rand32(), rand32(), rand32());
			end
		end
	endtask

	always @(posedge clk) begin
		range_t want;
		range_t got;
		if (arst_n && done) begin
			got = '{iter_start, iter_count, iter_count_hint, has_work,
				acquire_start, acquire_size, acquire_size_hint};
			if (ranges_due.size() == 0) begin
				$error("unexpected result word");
				errors++;
			end else begin
				want = ranges_due.pop_front();
				if (got.iter_start !== want.iter_start) begin
					$error("iter_start exp %h got %h", want.iter_start, got.iter_start);
					errors++;
				end
				if (got.iter_count !== want.iter_count) begin
					$error("iter_count exp %h got %h", want.iter_count, got.iter_count);
					errors++;
				end
				if (got.iter_count_hint !== want.iter_count_hint) begin
					$error("iter_count_hint exp %h got %h", want.iter_count_hint,
						got.iter_count_hint);
					errors++;
				end
				if (got.has_work !== want.has_work) begin
					$error("has_work exp %b got %b", want.has_work, got.has_work);
					errors++;
				end
				if (got.acquire_start !== want.acquire_start) begin
					$error("acquire_start exp %h got %h", want.acquire_start,
						got.acquire_start);
					errors++;
				end
				if (got.acquire_size !== want.acquire_size) begin
					$error("acquire_size exp %h got %h", want.acquire_size, got.acquire_size);
					errors++;
				end
				if (got.acquire_size_hint !== want.acquire_size_hint) begin
					$error("acquire_size_hint exp %h got %h", want.acquire_size_hint,
						got.acquire_size_hint);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we)
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt > 20 * LCRP_LATENCY + 2000) begin
			$display("loop_chunk_range_partitioner test failed");
			$finish;
		end
	end

	initial begin
		gap_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		worker_id = '0;
		total_iterations = '0;
		total_chunks = '0;
		chunk_size = '0;
		cfg_we = 1'b0;
		cfg_idx = CFG_MODE;
		cfg_wdata = '0;
		mode_q = MODE_FLAT;
		workers_q = 17'd1;
		per_node_q = 17'd1;
		columns_q = 17'd1;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		send_query(16'd0, 32'd10, 32'd4, 32'd3);
		test_directed();
		gap_pct = 37;
		test_random(5);
		gap_pct = 54;
		test_random(5);
		gap_pct = 0;
		test_random(4);
		drain();
		if (errors == 0)
			$display("loop_chunk_range_partitioner test passed");
		else
			$display("loop_chunk_range_partitioner test failed");
		$finish;
	end
endmodule

`default_nettype wire
